// ----- sv/first_fit_region_allocator_defines.svh -----
// Assertion macros for the first-fit region allocator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FFRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FFRA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ffra_pkg.sv -----
// Shared types for the first-fit region allocator: codes, sequencer states,
// and the control and status structs. No dependencies.
`timescale 1ns / 1ps

package ffra_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_ALLOC  = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_BAD_REGION   = 3'd1,
    STS_NO_FIT       = 3'd2,
    STS_BAD_ID       = 3'd3,
    STS_ALREADY_FREE = 3'd4,
    STS_LIST_FULL    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_OWN,
    S_SCAN,
    S_SHIFT
  } seq_state_e;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_OWN,
    SRC_FREE
  } src_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_DOWN,
    RD_UP
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ALLOC,
    RES_LOOK
  } res_sel_e;

  typedef struct packed {
    logic bad_rng;
    logic fits;
    logic exact;
  } alu_flags_t;

  typedef struct packed {
    action_e    act;
    logic       id_ok;
    logic       size_zero;
    logic       list_full;
    logic       list_empty;
    logic       own_zero;
    logic       ptr_head;
    logic       ptr_zero;
    alu_flags_t flags;
  } seq_stat_t;

  typedef struct packed {
    logic     capture;
    src_e     src;
    logic     fl_push;
    logic     fl_shrink;
    logic     fl_shift;
    logic     cnt_dec;
    logic     rd_ld;
    rd_sel_e  rd_sel;
    logic     own_wr;
    logic     own_clr;
    res_sel_e res_sel;
    logic     finish;
    status_e  st;
  } seq_ctrl_t;

endpackage

// ----- sv/first_fit_region_allocator.sv -----
// Top level of the first-fit region allocator: command registers, free list
// and id table RAMs, shared range unit and sequencer.
// Depends on ffra_pkg, ffra_ram, ffra_alu, ffra_seq and the defines header.
`timescale 1ns / 1ps
`include "first_fit_region_allocator_defines.svh"

// A command beat is taken at a rising edge with start high and busy low.
// The action selects add free region, allocate, free or lookup. busy stays
// high while the command runs, and no new beat is taken meanwhile.
// Each command gives exactly one result beat: done_o is high for one cycle
// with status_o, address_o and length_o. The receiver cannot stall, so the
// beat is gone after that cycle; the block is idle again in the same cycle.
// Steps from the accepting edge to the result cycle:
//   add, and any command rejected on its inputs: the dispatch state alone.
//   free and lookup: dispatch, then one registered read of the id table.
//   allocate: dispatch, then the scan, in which free list entries are
//   examined newest first, one per cycle through the shared range unit,
//   then, after an exact fit, the newer entries are moved down one place.
//   With the default depth of 32 the longest allocate is an exact fit on
//   the oldest of 32 entries.
// The free list lives in a RAM stored oldest first; it needs no clearing.
// Reset empties the free list and marks every id table entry as cleared.
module first_fit_region_allocator #(
  parameter int unsigned FREE_LIST_DEPTH = 32,
  parameter int unsigned ID_TABLE_SIZE   = 32,
  parameter int unsigned ADDRESS_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [7:0]  region_id_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] address_o,
  output logic [31:0] length_o
);
  import ffra_pkg::*;

  localparam int unsigned AW  = ADDRESS_WIDTH;
  localparam int unsigned IXW = $clog2(FREE_LIST_DEPTH);
  localparam int unsigned CW  = $clog2(FREE_LIST_DEPTH + 1);
  localparam int unsigned OIW = $clog2(ID_TABLE_SIZE);

  action_e         act_q;
  logic [7:0]      id_q;
  logic [AW-1:0]   size_q, rs_q, re_q;
  logic [CW-1:0]   cnt_q;
  logic [IXW-1:0]  ptr_q;
  logic [ID_TABLE_SIZE-1:0] own_vld_q;
  logic            done_q;
  status_e         status_q;
  logic [AW-1:0]   addr_q, len_q;

  seq_stat_t       stat;
  seq_ctrl_t       ctrl;
  alu_flags_t      flags;
  logic [AW-1:0]   op_s, op_e, diff, sum;
  logic [AW-1:0]   own_s, own_e;
  logic [2*AW-1:0] fl_rdata, fl_wdata, own_rdata;
  logic [IXW-1:0]  fl_waddr, fl_raddr;
  logic            fl_we;
  logic [OIW-1:0]  own_idx;
  logic            own_hit;

  assign own_idx = id_q[OIW-1:0];
  assign own_hit = own_vld_q[own_idx];
  assign own_s   = own_hit ? own_rdata[2*AW-1:AW] : '0;
  assign own_e   = own_hit ? own_rdata[AW-1:0] : '0;

  always_comb begin
    case (ctrl.src)
      SRC_OWN: begin
        op_s = own_s;
        op_e = own_e;
      end
      SRC_FREE: begin
        op_s = fl_rdata[2*AW-1:AW];
        op_e = fl_rdata[AW-1:0];
      end
      default: begin
        op_s = rs_q;
        op_e = re_q;
      end
    endcase
  end

  ffra_alu #(
    .AW(AW)
  ) u_alu (
    .s_i    (op_s),
    .e_i    (op_e),
    .size_i (size_q),
    .diff_o (diff),
    .sum_o  (sum),
    .flags_o(flags)
  );

  always_comb begin
    stat.act        = act_q;
    stat.id_ok      = ({1'b0, id_q} < 9'(ID_TABLE_SIZE));
    stat.size_zero  = (size_q == '0);
    stat.list_full  = (cnt_q == CW'(FREE_LIST_DEPTH));
    stat.list_empty = (cnt_q == '0);
    stat.own_zero   = (own_s == '0) && (own_e == '0);
    stat.ptr_head   = ((CW'(ptr_q) + CW'(1)) == cnt_q);
    stat.ptr_zero   = (ptr_q == '0);
    stat.flags      = flags;
  end

  ffra_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // Free list: physical slot cnt-1 holds the head, slot 0 the oldest entry.
  always_comb begin
    case (ctrl.rd_sel)
      RD_DOWN: fl_raddr = ptr_q - IXW'(1);
      RD_UP:   fl_raddr = ptr_q + IXW'(1);
      default: fl_raddr = IXW'(cnt_q - CW'(1));
    endcase
  end

  always_comb begin
    fl_we    = ctrl.fl_push | ctrl.fl_shrink | ctrl.fl_shift;
    fl_waddr = IXW'(cnt_q);
    fl_wdata = {op_s, op_e};
    if (ctrl.fl_shift) begin
      fl_waddr = ptr_q - IXW'(1);
      fl_wdata = fl_rdata;
    end else if (ctrl.fl_shrink) begin
      fl_waddr = ptr_q;
      fl_wdata = {sum, op_e};
    end
  end

  ffra_ram #(
    .WIDTH(2 * AW),
    .DEPTH(FREE_LIST_DEPTH)
  ) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (fl_we),
    .waddr_i(fl_waddr),
    .wdata_i(fl_wdata),
    .raddr_i(fl_raddr),
    .rdata_o(fl_rdata)
  );

  ffra_ram #(
    .WIDTH(2 * AW),
    .DEPTH(ID_TABLE_SIZE)
  ) u_own_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl.own_wr),
    .waddr_i(own_idx),
    .wdata_i({op_s, sum}),
    .raddr_i(own_idx),
    .rdata_o(own_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.capture) begin
      act_q  <= action_e'(action_i);
      id_q   <= region_id_i;
      size_q <= AW'(request_size_i);
      rs_q   <= AW'(region_start_i);
      re_q   <= AW'(region_end_i);
    end
    if (ctrl.rd_ld) begin
      ptr_q <= fl_raddr;
    end
    if (ctrl.capture) begin
      addr_q <= '0;
      len_q  <= '0;
    end else if (ctrl.res_sel == RES_ALLOC) begin
      addr_q <= op_s;
      len_q  <= size_q;
    end else if (ctrl.res_sel == RES_LOOK) begin
      addr_q <= op_s;
      len_q  <= diff;
    end
    if (ctrl.finish) begin
      status_q <= ctrl.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      own_vld_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= ctrl.finish;
      if (ctrl.fl_push) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (ctrl.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (ctrl.own_wr) begin
        own_vld_q[own_idx] <= 1'b1;
      end else if (ctrl.own_clr) begin
        own_vld_q[own_idx] <= 1'b0;
      end
    end
  end

  assign done_o    = done_q;
  assign status_o  = status_q;
  assign address_o = 32'(addr_q);
  assign length_o  = 32'(len_q);

  `FFRA_ASSERT_NXT(a_single_beat, done_o, !done_o, "result beat lasted more than one cycle")
  `FFRA_ASSERT_IMP(a_done_idle, done_o, !busy, "result beat shown while still busy")
  `FFRA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
  `FFRA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(FREE_LIST_DEPTH), "free list count overflow")

endmodule

// ----- sv/ffra_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ffra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/ffra_alu.sv -----
// Shared range unit: region length, fit and exact-fit tests, and the
// shrunk start address. Depends on ffra_pkg.
`timescale 1ns / 1ps

module ffra_alu #(
  parameter int unsigned AW = 32
) (
  input  logic [AW-1:0]        s_i,
  input  logic [AW-1:0]        e_i,
  input  logic [AW-1:0]        size_i,
  output logic [AW-1:0]        diff_o,
  output logic [AW-1:0]        sum_o,
  output ffra_pkg::alu_flags_t flags_o
);
  import ffra_pkg::*;

  assign diff_o          = e_i - s_i;
  assign sum_o           = s_i + size_i;
  assign flags_o.bad_rng = (s_i >= e_i);
  assign flags_o.fits    = (s_i < e_i) && (size_i <= diff_o);
  assign flags_o.exact   = (size_i == diff_o);

endmodule

// ----- sv/ffra_seq.sv -----
// Sequencer of the allocator: decodes the command, walks the free list and
// compacts it after an exact fit. Depends on ffra_pkg.
`timescale 1ns / 1ps

module ffra_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ffra_pkg::seq_stat_t stat_i,
  output ffra_pkg::seq_ctrl_t ctrl_o,
  output logic                busy_o
);
  import ffra_pkg::*;

  seq_state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      S_IDLE: begin
        ctrl_o.capture = start_i;
      end
      S_DISPATCH: begin
        ctrl_o.src    = SRC_IN;
        ctrl_o.finish = 1'b1;
        case (stat_i.act)
          ACT_ADD: begin
            if (stat_i.flags.bad_rng) begin
              ctrl_o.st = STS_BAD_REGION;
            end else if (stat_i.list_full) begin
              ctrl_o.st = STS_LIST_FULL;
            end else begin
              ctrl_o.fl_push = 1'b1;
            end
          end
          ACT_ALLOC: begin
            if (!stat_i.id_ok) begin
              ctrl_o.st = STS_BAD_ID;
            end else if (stat_i.size_zero) begin
              ctrl_o.st = STS_BAD_REGION;
            end else if (stat_i.list_empty) begin
              ctrl_o.st = STS_NO_FIT;
            end else begin
              ctrl_o.finish = 1'b0;
              ctrl_o.rd_ld  = 1'b1;
              ctrl_o.rd_sel = RD_HEAD;
            end
          end
          default: begin
            if (!stat_i.id_ok) begin
              ctrl_o.st = STS_BAD_ID;
            end else begin
              ctrl_o.finish = 1'b0;
            end
          end
        endcase
      end
      S_OWN: begin
        ctrl_o.src    = SRC_OWN;
        ctrl_o.finish = 1'b1;
        if (stat_i.act == ACT_LOOKUP) begin
          ctrl_o.res_sel = RES_LOOK;
        end else if (stat_i.own_zero) begin
          ctrl_o.st = STS_ALREADY_FREE;
        end else if (stat_i.flags.bad_rng) begin
          ctrl_o.st = STS_BAD_REGION;
        end else if (stat_i.list_full) begin
          ctrl_o.st = STS_LIST_FULL;
        end else begin
          ctrl_o.fl_push = 1'b1;
          ctrl_o.own_clr = 1'b1;
        end
      end
      S_SCAN: begin
        ctrl_o.src = SRC_FREE;
        if (stat_i.flags.fits) begin
          ctrl_o.own_wr  = 1'b1;
          ctrl_o.res_sel = RES_ALLOC;
          if (!stat_i.flags.exact) begin
            ctrl_o.fl_shrink = 1'b1;
            ctrl_o.finish    = 1'b1;
          end else if (stat_i.ptr_head) begin
            ctrl_o.cnt_dec = 1'b1;
            ctrl_o.finish  = 1'b1;
          end else begin
            ctrl_o.rd_ld  = 1'b1;
            ctrl_o.rd_sel = RD_UP;
          end
        end else if (stat_i.ptr_zero) begin
          ctrl_o.st     = STS_NO_FIT;
          ctrl_o.finish = 1'b1;
        end else begin
          ctrl_o.rd_ld  = 1'b1;
          ctrl_o.rd_sel = RD_DOWN;
        end
      end
      S_SHIFT: begin
        ctrl_o.src      = SRC_FREE;
        ctrl_o.fl_shift = 1'b1;
        if (stat_i.ptr_head) begin
          ctrl_o.cnt_dec = 1'b1;
          ctrl_o.finish  = 1'b1;
        end else begin
          ctrl_o.rd_ld  = 1'b1;
          ctrl_o.rd_sel = RD_UP;
        end
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (ctrl_o.finish) begin
          state_d = S_IDLE;
        end else if (stat_i.act == ACT_ALLOC) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_OWN;
        end
      end
      S_OWN: begin
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (ctrl_o.finish) begin
          state_d = S_IDLE;
        end else if (stat_i.flags.fits) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (ctrl_o.finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for first_fit_region_allocator: directed command beats,
// then random phases, checked against an in-bench mirror of the free list and id table.
// Depends on ffra_pkg and the first_fit_region_allocator top level.
`timescale 1ns / 1ps

module tb_top;
  import ffra_pkg::*;

  localparam int unsigned FREE_DEPTH = 32;
  localparam int unsigned ID_SLOTS   = 32;

  typedef struct {
    status_e     st;
    logic [31:0] addr;
    logic [31:0] len;
  } outcome_t;

  class allocator_mirror;
    logic [31:0] free_lo[$];
    logic [31:0] free_hi[$];
    bit   [31:0] own_lo[ID_SLOTS];
    bit   [31:0] own_hi[ID_SLOTS];
    outcome_t    outcome_q[$];
    int          errors;

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_command(action_e act, logic [7:0] id, logic [31:0] size,
                               logic [31:0] lo, logic [31:0] hi);
      outcome_t r;
      logic [31:0] s;
      logic [31:0] e;
      int k;
      r.st   = STS_OK;
      r.addr = '0;
      r.len  = '0;
      case (act)
        ACT_ADD: begin
          if (lo >= hi) r.st = STS_BAD_REGION;
          else if (free_lo.size() >= FREE_DEPTH) r.st = STS_LIST_FULL;
          else begin
            free_lo.push_front(lo);
            free_hi.push_front(hi);
          end
        end
        ACT_ALLOC: begin
          if (id >= ID_SLOTS) r.st = STS_BAD_ID;
          else if (size == 0) r.st = STS_BAD_REGION;
          else begin
            r.st = STS_NO_FIT;
            for (k = 0; k < free_lo.size() && r.st == STS_NO_FIT; k++) begin
              s = free_lo[k];
              e = free_hi[k];
              if (s < e && size <= e - s) begin
                own_lo[id] = s;
                own_hi[id] = s + size;
                r.st   = STS_OK;
                r.addr = s;
                r.len  = size;
                if (size < e - s) free_lo[k] = s + size;
                else begin
                  free_lo.delete(k);
                  free_hi.delete(k);
                end
              end
            end
          end
        end
        ACT_FREE: begin
          if (id >= ID_SLOTS) r.st = STS_BAD_ID;
          else if (own_lo[id] == 0 && own_hi[id] == 0) r.st = STS_ALREADY_FREE;
          else if (own_lo[id] >= own_hi[id]) r.st = STS_BAD_REGION;
          else if (free_lo.size() >= FREE_DEPTH) r.st = STS_LIST_FULL;
          else begin
            free_lo.push_front(own_lo[id]);
            free_hi.push_front(own_hi[id]);
            own_lo[id] = '0;
            own_hi[id] = '0;
          end
        end
        default: begin
          if (id >= ID_SLOTS) r.st = STS_BAD_ID;
          else begin
            r.addr = own_lo[id];
            r.len  = own_hi[id] - own_lo[id];
          end
        end
      endcase
      outcome_q.push_back(r);
    endfunction

    task check_beat(logic [2:0] st, logic [31:0] addr, logic [31:0] len);
      outcome_t x;
      if (outcome_q.size() == 0) begin
        report($sformatf("result beat with none expected: status %0d", st));
      end else begin
        x = outcome_q.pop_front();
        if (st !== x.st)
          report($sformatf("status got %0d expected %0d", st, x.st));
        if (addr !== x.addr)
          report($sformatf("address got %h expected %h", addr, x.addr));
        if (len !== x.len)
          report($sformatf("length got %h expected %h", len, x.len));
      end
    endtask
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [1:0]  action_i       = '0;
  logic [7:0]  region_id_i    = '0;
  logic [31:0] request_size_i = '0;
  logic [31:0] region_start_i = '0;
  logic [31:0] region_end_i   = '0;
  logic        busy;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] address_o;
  logic [31:0] length_o;

  allocator_mirror mirror;
  int              idle_pct;

  first_fit_region_allocator #(
    .FREE_LIST_DEPTH(FREE_DEPTH),
    .ID_TABLE_SIZE  (ID_SLOTS),
    .ADDRESS_WIDTH  (32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .region_id_i   (region_id_i),
    .request_size_i(request_size_i),
    .region_start_i(region_start_i),
    .region_end_i  (region_end_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .address_o     (address_o),
    .length_o      (length_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) mirror.check_beat(status_o, address_o, length_o);
  end

  initial begin
    #10_000_000;
    $display("first_fit_region_allocator test failed");
    $finish;
  end

  task automatic issue(action_e act, logic [7:0] id, logic [31:0] size,
                       logic [31:0] lo, logic [31:0] hi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    action_i       <= act;
    region_id_i    <= id;
    request_size_i <= size;
    region_start_i <= lo;
    region_end_i   <= hi;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    mirror.note_command(act, id, size, lo, hi);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (mirror.outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_command(int add_w);
    action_e     act;
    logic [7:0]  id;
    logic [31:0] size;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] span;
    int          sub;
    int          k;
    id   = 8'($urandom_range(ID_SLOTS - 1));
    if ($urandom_range(19) == 0) id = 8'($urandom);
    size = $urandom;
    lo   = $urandom;
    hi   = $urandom;
    if ($urandom_range(99) < add_w) begin
      act = ACT_ADD;
      case ($urandom_range(9))
        0: hi = lo;
        1: ;
        2: begin
          lo = '0;
          hi = $urandom_range(4096, 1);
        end
        3: begin
          hi = '1;
          lo = hi - $urandom_range(4096, 1);
        end
        default: begin
          span = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4096, 1);
          if (span == 0) span = 1;
          hi = (span > ~lo) ? 32'hFFFF_FFFF : lo + span;
        end
      endcase
    end else begin
      sub = $urandom_range(99);
      if (sub < 45) begin
        act = ACT_ALLOC;
        case ($urandom_range(9))
          0: size = '0;
          1: ;
          2, 3: begin
            if (mirror.free_lo.size() != 0) begin
              k    = $urandom_range(mirror.free_lo.size() - 1);
              size = mirror.free_hi[k] - mirror.free_lo[k];
            end
          end
          default: size = $urandom_range(256, 1);
        endcase
      end else if (sub < 80) begin
        act = ACT_FREE;
        for (k = 0; k < 4 && id < ID_SLOTS; k++) begin
          if (mirror.own_lo[id] == 0 && mirror.own_hi[id] == 0)
            id = 8'($urandom_range(ID_SLOTS - 1));
        end
      end else begin
        act = ACT_LOOKUP;
      end
    end
    issue(act, id, size, lo, hi);
  endtask

  initial begin
    int phase;
    int n;
    int add_w;
    int pct[4];
    pct = '{0, 71, 17, 0};
    mirror   = new;
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(ACT_LOOKUP, 8'd0,   32'd0,          32'd0,          32'd0);
    issue(ACT_FREE,   8'd0,   32'd0,          32'd0,          32'd0);
    issue(ACT_ALLOC,  8'd0,   32'd16,         32'd0,          32'd0);
    issue(ACT_ADD,    8'd0,   32'd0,          32'd5,          32'd5);
    issue(ACT_ADD,    8'd0,   32'd0,          32'hFFFF_FFFF,  32'd0);
    issue(ACT_ADD,    8'd0,   32'd0,          32'd0,          32'h100);
    issue(ACT_ADD,    8'd0,   32'd0,          32'hFFFF_FF00,  32'hFFFF_FFFF);
    issue(ACT_ALLOC,  8'd0,   32'd0,          32'd0,          32'd0);
    issue(ACT_ALLOC,  8'd32,  32'd1,          32'd0,          32'd0);
    issue(ACT_ALLOC,  8'd255, 32'd1,          32'd0,          32'd0);
    issue(ACT_FREE,   8'd32,  32'd0,          32'd0,          32'd0);
    issue(ACT_LOOKUP, 8'd255, 32'd0,          32'd0,          32'd0);
    issue(ACT_ALLOC,  8'd1,   32'h10,         32'd0,          32'd0);
    issue(ACT_ALLOC,  8'd2,   32'hEF,         32'd0,          32'd0);
    issue(ACT_ALLOC,  8'd3,   32'hFFFF_FFFF,  32'd0,          32'd0);
    issue(ACT_LOOKUP, 8'd1,   32'd0,          32'd0,          32'd0);
    issue(ACT_LOOKUP, 8'd2,   32'd0,          32'd0,          32'd0);
    issue(ACT_ALLOC,  8'd1,   32'h100,        32'd0,          32'd0);
    issue(ACT_FREE,   8'd1,   32'd0,          32'd0,          32'd0);
    issue(ACT_FREE,   8'd1,   32'd0,          32'd0,          32'd0);
    issue(ACT_ADD,    8'd0,   32'd0,          32'h1000,       32'h1010);
    issue(ACT_ADD,    8'd0,   32'd0,          32'h2000,       32'h2008);
    issue(ACT_ALLOC,  8'd4,   32'h10,         32'd0,          32'd0);
    issue(ACT_LOOKUP, 8'd4,   32'd0,          32'd0,          32'd0);
    drain();

    // Fill-heavy, balanced and drain-heavy stretches are picked at random so the
    // list can both fill up and empty out in each phase, with or without idling.
    add_w = 30;
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = pct[phase];
      for (n = 0; n < 360; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: add_w = 15;
            1: add_w = 30;
            default: add_w = 65;
          endcase
        end
        random_command(add_w);
      end
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("first_fit_region_allocator test passed");
    end else begin
      $display("first_fit_region_allocator test failed");
    end
    $finish;
  end

endmodule
